FILE: rtl/fhbt_pkg.sv
package fhbt_pkg;

  // Operation codes carried on func_i.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  // Result codes driven on status_o.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_ZERO_DATA = 2'd3
  } status_e;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  // The FNV prime is 2**40 + 0x1b3, so a multiply is a shift plus a small product.
  localparam int unsigned FNV_PRIME_SHIFT = 40;
  localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CFG_BITS = 11;
  localparam int unsigned HASH_STEPS = 4;   // one key byte per cycle
  localparam int unsigned DIV_RADIX = 4;    // hash bits folded into the remainder per cycle
  localparam int unsigned DIV_STEPS = 64 / DIV_RADIX;

endpackage

FILE: rtl/fnv_hashed_bucket_table.sv
// Channel   Direction  Ports                                   Handshake
// request   in         func_i, lookup_key_i, payload_in_i      start_i high, busy_o low
// result    out        status_o, payload_out_o                 done_o, one cycle, no stall
// config    in         cfg_data_i                              cfg_valid_i and cfg_ready_o
//
// After the accepting edge a request runs through S_HASH (FNV-1a hashing,
// one key byte per cycle), S_DIV (remainder division by the bucket count,
// 4 bits per cycle), S_READ (bucket row read) and S_EXEC (read-modify-write
// of the row that registers the result word). busy_o falls with the strobe,
// so the next request is taken at the earliest at the edge that ends the
// strobe cycle.
// After reset a clearing pass writes every bucket row while busy_o stays
// high; configuration writes are taken at all times.
// The receiver cannot stall: done_o is high for exactly one cycle per request.
module fnv_hashed_bucket_table
  import fhbt_pkg::*;
#(
  parameter int unsigned BUCKETS   = 1024,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic signed [31:0]   lookup_key_i,
  input  logic [31:0]          payload_in_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [31:0]          payload_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_BITS-1:0]  cfg_data_i
);

  // Stored data never needs more bits than the request word carries.
  localparam int unsigned DW  = (DATA_BITS < WORD_BITS) ? DATA_BITS : WORD_BITS;
  localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CW  = $clog2(BUCKETS + 1);
  localparam int unsigned EW  = 1 + KEY_BITS + DW;   // one way: valid, key, data
  localparam int unsigned RW  = WAYS * EW;           // one bucket row
  localparam int unsigned OFS_DATA = 0;
  localparam int unsigned OFS_KEY  = DW;
  localparam int unsigned OFS_VAL  = DW + KEY_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_DIV   = 6'b001000,
    S_READ  = 6'b010000,
    S_EXEC  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [BW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     nbkt_q, nbkt_d;
  logic [63:0]       hash_q, hash_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [1:0]        func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [DW-1:0]     data_q;
  logic              done_q;
  logic [1:0]        status_q;
  logic [WORD_BITS-1:0] pout_q;

  // Bucket memory, one row per bucket, registered read port.
  logic [RW-1:0]     mem_q [BUCKETS];
  logic [RW-1:0]     rd_q;
  logic              wr_en;
  logic [BW-1:0]     wr_addr;
  logic [RW-1:0]     wr_row;

  logic              accept;
  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign payload_out_o = pout_q;

  // The bucket count register holds the effective divisor, already clamped.
  always_comb begin
    nbkt_d = nbkt_q;
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        nbkt_d = CW'(1);
      end else if (32'(cfg_data_i) > 32'(BUCKETS)) begin
        nbkt_d = CW'(BUCKETS);
      end else begin
        nbkt_d = CW'(cfg_data_i);
      end
    end
  end

  // One FNV-1a round: fold in the current key byte, then multiply by the prime.
  logic [7:0]  hash_byte;
  logic [63:0] hash_x;
  logic [63:0] hash_step;
  assign hash_byte = key_q[{cnt_q[1:0], 3'b000} +: 8];
  assign hash_x    = hash_q ^ {56'd0, hash_byte};
  assign hash_step = (hash_x << FNV_PRIME_SHIFT) + 64'(hash_x * FNV_PRIME_LO);

  // Restoring division, most significant hash bits first; only the remainder is kept.
  logic [CW:0]   div_t;
  logic [CW-1:0] div_rem;
  logic [63:0]   div_sh;
  always_comb begin
    div_rem = rem_q;
    div_sh  = hash_q;
    div_t   = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      div_t  = {div_rem, div_sh[63]};
      div_sh = div_sh << 1;
      if (div_t >= {1'b0, nbkt_q}) begin
        div_t = div_t - {1'b0, nbkt_q};
      end
      div_rem = div_t[CW-1:0];
    end
  end

  // Bucket row update. Valid ways always form a prefix, so the lowest
  // matching way is the oldest and the lowest empty way is the append point.
  logic [WAYS-1:0] way_val;
  logic [WAYS-1:0] way_hit;
  logic [KEY_BITS-1:0] way_key [WAYS];
  logic [DW-1:0]   way_data [WAYS];
  logic            hit_any, free_any;
  logic [$clog2(WAYS+1)-1:0] hit_way, free_way;
  logic [RW-1:0]   new_row;
  logic [1:0]      ex_status;
  logic [WORD_BITS-1:0] ex_pout;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_val[w]  = rd_q[w*EW + OFS_VAL];
      way_key[w]  = rd_q[w*EW + OFS_KEY +: KEY_BITS];
      way_data[w] = rd_q[w*EW + OFS_DATA +: DW];
      way_hit[w]  = way_val[w] && (way_key[w] == key_q);
    end
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        hit_any = 1'b1;
        hit_way = ($clog2(WAYS+1))'(w);
      end
      if (!way_val[w]) begin
        free_any = 1'b1;
        free_way = ($clog2(WAYS+1))'(w);
      end
    end

    new_row   = rd_q;
    ex_status = STATUS_NOT_FOUND;
    ex_pout   = '0;
    unique case (func_q) inside
      FUNC_INSERT: begin
        if (data_q == '0) begin
          ex_status = STATUS_ZERO_DATA;
        end else if (!free_any) begin
          ex_status = STATUS_FULL;
        end else begin
          ex_status = STATUS_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (($clog2(WAYS+1))'(w) == free_way) begin
              new_row[w*EW +: EW] = {1'b1, key_q, data_q};
            end
          end
        end
      end
      FUNC_FIND, FUNC_REMOVE: begin
        if (hit_any) begin
          ex_status = STATUS_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (($clog2(WAYS+1))'(w) == hit_way) begin
              ex_pout = WORD_BITS'(way_data[w]);
            end
          end
          if (func_q == FUNC_REMOVE) begin
            // Later ways move up one place; the last way empties.
            for (int w = 0; w < WAYS; w++) begin
              if (($clog2(WAYS+1))'(w) >= hit_way) begin
                if (w == WAYS - 1) begin
                  new_row[w*EW + OFS_VAL] = 1'b0;
                end else begin
                  new_row[w*EW +: EW] = rd_q[(w+1)*EW +: EW];
                end
              end
            end
          end
        end
      end
      default: begin
        ex_status = STATUS_NOT_FOUND;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    hash_d  = hash_q;
    rem_d   = rem_q;
    wr_en   = 1'b0;
    wr_addr = rem_q[BW-1:0];
    wr_row  = new_row;
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = '0;
        clr_d   = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
          cnt_d   = '0;
          hash_d  = FNV_BASIS;
        end
      end
      S_HASH: begin
        hash_d = hash_step;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(HASH_STEPS - 1)) begin
          state_d = S_DIV;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      S_DIV: begin
        rem_d  = div_rem;
        hash_d = div_sh;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        wr_en   = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
      nbkt_q  <= CW'(BUCKETS);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      nbkt_q  <= nbkt_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    rem_q  <= rem_d;
    if (accept) begin
      func_q <= func_i;
      key_q  <= KEY_BITS'(lookup_key_i);
      data_q <= payload_in_i[DW-1:0];
    end
    if (state_q == S_EXEC) begin
      status_q <= ex_status;
      pout_q   <= ex_pout;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (state_q == S_READ) begin
      rd_q <= mem_q[rem_q[BW-1:0]];
    end
  end

  // A result appears only right after the row update cycle.
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_EXEC))
    else $error("result strobe without a row update");

  // An accepted request always starts hashing in the next cycle.
  a_accept_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_HASH))
    else $error("accepted request did not start hashing");

  // Refused or missed requests never return data.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != STATUS_OK)) |-> (pout_q == '0))
    else $error("failed request returned data");

  // The bucket index never reaches the configured count.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rem_q < nbkt_q))
    else $error("bucket index out of range");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fhbt_pkg::*;

  localparam int unsigned NUM_BUCKETS = 1024;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned SETTLE_CYCLES = 40;
  // The limit allows for every word plus sender gaps and the clearing pass.
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] func_i = FUNC_INSERT;
  logic signed [31:0] lookup_key_i = '0;
  logic [31:0] payload_in_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic busy_o, done_o, cfg_ready_o;
  logic [1:0] status_o;
  logic [31:0] payload_out_o;

  fnv_hashed_bucket_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .func_i(func_i), .lookup_key_i(lookup_key_i), .payload_in_i(payload_in_i),
    .done_o(done_o), .status_o(status_o), .payload_out_o(payload_out_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A result word as the table is expected to answer it.
  typedef struct packed {
    logic [1:0] status;
    logic [31:0] data;
  } answer_t;

  // Model of the table contents: per bucket an ordered list of key and data.
  logic model_valid [NUM_BUCKETS][NUM_WAYS];
  logic [31:0] model_key [NUM_BUCKETS][NUM_WAYS];
  logic [31:0] model_data [NUM_BUCKETS][NUM_WAYS];
  logic [CFG_BITS-1:0] model_count;

  answer_t pending_answers[$];
  int unsigned mismatches = 0;
  bit failed = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] fnv1a_of_key(logic [31:0] key);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int i = 0; i < 4; i++) begin
      h = h ^ {56'd0, key[8*i +: 8]};
      h = h * 64'h100000001b3;
    end
    return h;
  endfunction

  function automatic int unsigned bucket_of_key(logic [31:0] key);
    logic [63:0] n;
    n = {53'd0, model_count};
    if (n == 0) n = 1;
    if (n > NUM_BUCKETS) n = NUM_BUCKETS;
    return int'(fnv1a_of_key(key) % n);
  endfunction

  // Applies one request to the model and returns the answer it must produce.
  function automatic answer_t table_access(logic [1:0] func, logic [31:0] key,
                                           logic [31:0] data);
    answer_t a;
    int unsigned b;
    int w;
    a = '{status: STATUS_NOT_FOUND, data: '0};
    b = bucket_of_key(key);
    if (func == FUNC_INSERT) begin
      if (data == 0) begin
        a.status = STATUS_ZERO_DATA;
      end else begin
        w = 0;
        while (w < NUM_WAYS && model_valid[b][w]) w++;
        if (w >= NUM_WAYS) begin
          a.status = STATUS_FULL;
        end else begin
          model_valid[b][w] = 1'b1;
          model_key[b][w] = key;
          model_data[b][w] = data;
          a.status = STATUS_OK;
        end
      end
    end else if (func == FUNC_FIND || func == FUNC_REMOVE) begin
      w = 0;
      while (w < NUM_WAYS && model_valid[b][w] && model_key[b][w] != key) w++;
      if (w < NUM_WAYS && model_valid[b][w]) begin
        a.status = STATUS_OK;
        a.data = model_data[b][w];
        if (func == FUNC_REMOVE) begin
          // Later entries move up one way so the list stays a prefix.
          for (; w + 1 < NUM_WAYS; w++) begin
            model_valid[b][w] = model_valid[b][w+1];
            model_key[b][w] = model_key[b][w+1];
            model_data[b][w] = model_data[b][w+1];
          end
          model_valid[b][NUM_WAYS-1] = 1'b0;
        end
      end
    end
    return a;
  endfunction

  // Result checker: every done_o strobe must match the oldest pending answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d data %h", status_o, payload_out_o);
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status || payload_out_o !== want.data) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d data %h, got status %0d data %h",
                     want.status, want.data, status_o, payload_out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sender burst shaping: a burst of back-to-back words, mostly followed by a random gap.
  // start_i stays high between words of a burst and drops only for a gap.
  int burst_left = 0;

  task automatic send_word(logic [1:0] func, logic [31:0] key, logic [31:0] data,
                           bit has_fixed, answer_t fixed);
    answer_t a;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    func_i <= func;
    lookup_key_i <= key;
    payload_in_i <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    a = table_access(func, key, data);
    // Rows with an answer readable at a glance are checked against it too.
    if (has_fixed && a != fixed) begin
      failed = 1'b1;
      $display("directed row disagrees with model for key %h", key);
    end
    pending_answers.push_back(a);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [CFG_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_count = value;
  endtask

  // Directed rows: func, key, data, whether an answer is fixed, and that answer.
  typedef struct {
    logic [1:0] func;
    logic [31:0] key;
    logic [31:0] data;
    bit fixed;
    answer_t want;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{FUNC_FIND,    32'h0000_0000, 32'h0,          1, '{STATUS_NOT_FOUND, 32'h0}},
    '{FUNC_REMOVE,  32'h8000_0000, 32'h0,          1, '{STATUS_NOT_FOUND, 32'h0}},
    '{FUNC_INSERT,  32'h7fff_ffff, 32'h0,          1, '{STATUS_ZERO_DATA, 32'h0}},
    '{FUNC_INSERT,  32'h7fff_ffff, 32'hffff_ffff,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_FIND,    32'h7fff_ffff, 32'h0,          1, '{STATUS_OK, 32'hffff_ffff}},
    '{FUNC_INSERT,  32'h8000_0000, 32'h0000_0001,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_INSERT,  32'hffff_ffff, 32'h1234_5678,  0, '{STATUS_OK, 32'h0}},
    '{FUNC_UNUSED,  32'h7fff_ffff, 32'hdead_beef,  1, '{STATUS_NOT_FOUND, 32'h0}},
    '{FUNC_REMOVE,  32'h8000_0000, 32'h0,          1, '{STATUS_OK, 32'h1}},
    '{FUNC_FIND,    32'h8000_0000, 32'h0,          1, '{STATUS_NOT_FOUND, 32'h0}},
    '{FUNC_REMOVE,  32'hffff_ffff, 32'h0,          0, '{STATUS_OK, 32'h0}}
  };

  // With a single bucket all keys collide, so full, duplicate and mid-list
  // removal cases follow from a short fixed sequence.
  stim_row_t one_bucket_rows[] = '{
    '{FUNC_INSERT,  32'h0000_0011, 32'haaaa_0001,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_INSERT,  32'h0000_0022, 32'haaaa_0002,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_INSERT,  32'h0000_0011, 32'haaaa_0003,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_INSERT,  32'h0000_0033, 32'haaaa_0004,  1, '{STATUS_OK, 32'h0}},
    '{FUNC_INSERT,  32'h0000_0044, 32'haaaa_0005,  1, '{STATUS_FULL, 32'h0}},
    '{FUNC_INSERT,  32'h0000_0044, 32'h0,          1, '{STATUS_ZERO_DATA, 32'h0}},
    '{FUNC_FIND,    32'h0000_0011, 32'h0,          1, '{STATUS_OK, 32'haaaa_0001}},
    '{FUNC_REMOVE,  32'h0000_0022, 32'h0,          1, '{STATUS_OK, 32'haaaa_0002}},
    '{FUNC_REMOVE,  32'h0000_0011, 32'h0,          1, '{STATUS_OK, 32'haaaa_0001}},
    '{FUNC_FIND,    32'h0000_0011, 32'h0,          1, '{STATUS_OK, 32'haaaa_0003}},
    '{FUNC_FIND,    32'h0000_0033, 32'h0,          1, '{STATUS_OK, 32'haaaa_0004}},
    '{FUNC_INSERT,  32'h0000_0055, 32'haaaa_0006,  1, '{STATUS_OK, 32'h0}}
  };

  // Keys come from a small pool so finds and removes hit often.
  logic [31:0] key_pool[16];

  task automatic random_phase(int unsigned words, int unsigned pool_used);
    logic [1:0] f;
    logic [31:0] k, d;
    int unsigned pick;
    for (int unsigned i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      f = pick < 45 ? FUNC_INSERT : pick < 75 ? FUNC_FIND : pick < 97 ? FUNC_REMOVE
                                                         : FUNC_UNUSED;
      k = $urandom_range(0, 9) == 0 ? $urandom() : key_pool[$urandom_range(0, pool_used-1)];
      d = $urandom_range(0, 19) == 0 ? 32'h0 : $urandom();
      send_word(f, k, d, 0, '{STATUS_OK, 32'h0});
    end
  endtask

  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++)
      for (int w = 0; w < NUM_WAYS; w++) model_valid[b][w] = 1'b0;
    model_count = CFG_BITS'(NUM_BUCKETS);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the bucket count, with the field extremes.
    foreach (directed_rows[i])
      send_word(directed_rows[i].func, directed_rows[i].key, directed_rows[i].data,
                directed_rows[i].fixed, directed_rows[i].want);
    drain_results();

    // Zero is treated as one bucket, so every key shares the same list.
    write_bucket_count('0);
    foreach (one_bucket_rows[i])
      send_word(one_bucket_rows[i].func, one_bucket_rows[i].key, one_bucket_rows[i].data,
                one_bucket_rows[i].fixed, one_bucket_rows[i].want);
    drain_results();

    foreach (key_pool[i]) key_pool[i] = $urandom();

    // Random phases across counts: tiny tables fill up, large ones rarely collide.
    // Stored entries stay where they are when the count changes.
    write_bucket_count(CFG_BITS'(1));
    random_phase(150, 16);
    drain_results();
    write_bucket_count(CFG_BITS'(3));
    random_phase(200, 16);
    drain_results();
    write_bucket_count(CFG_BITS'(2047));  // saturates to the full table
    random_phase(150, 8);
    drain_results();
    write_bucket_count(CFG_BITS'($urandom_range(2, 1023)));
    random_phase(150, 16);
    drain_results();
    write_bucket_count(CFG_BITS'(1024));
    random_phase(150, 12);
    drain_results();
    write_bucket_count(CFG_BITS'($urandom_range(1025, 2047)));
    random_phase(RANDOM_WORDS - 800, 16);
    drain_results();

    if (!failed && mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fhbt_pkg.sv
rtl/fnv_hashed_bucket_table.sv
tb/sv/testbench.sv
